// ===== design/matrix_vector_multiply_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define MVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvm assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvm assertion failed");

`endif

// ===== design/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Types, widths and helpers shared by the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int VALUE_W         = 32;
    localparam int COL_W           = 9;
    localparam int ROW_W           = 9;
    localparam int CFG_W           = 10;
    localparam int ACC_W           = 64;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 48;
    localparam int M_PAD_W         = M_TDATA_W - ROW_W - VALUE_W;
    localparam int MAX_COLUMNS_DEF = 512;
    localparam int INDEX_SPAN      = 512;
    localparam int ROW_SPAN        = 512;
    localparam int ROUND_HALF      = 32768;
    localparam int FRAC_W          = 16;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } cmd_t;

    typedef enum logic
    {
        CFG_COLUMNS = 1'b0,
        CFG_ROWS    = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0] sum;
        logic                      sat;
    } round_res_t;

    // 64-bit add that clips at the signed limits
    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] sum;
        logic signed [ACC_W-1:0] res;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Dense matrix-vector multiply, signed Q16.16, one element per cycle unless the output holds the pipe.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_*: s_tuser selects a vector load (0) or a matrix element
//   (1); s_tdata carries the column index and the Q16.16 value. Load the
//   vector first, then stream the matrix row-major. The row sum leaves on m_*
//   when the element of the last configured column arrives, with its row number
//   and a clip flag on m_tuser.
//   Throughput is one word per cycle, loads and matrix elements alike. The
//   vector store is a single-port read, one-port write memory; a matrix word
//   reads it in its accept cycle, so a load is visible to the very next word.
//   m_tvalid rises once the last-column word has passed the memory read at
//   the accept edge, then multiply, accumulate, and round into the output.
//   Reset clears the accumulator, the row number and the control state, and
//   sets column_count to 512 and row_count to 1; the vector store is not
//   cleared. When the receiver stalls, result-free words keep flowing; the
//   pipeline holds only when a second row sum meets a result still waiting.
//   Write cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // column_index, value, zero pad
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // row_sum, row_number, zero pad
    output logic                 m_tuser    // saturated
);

    localparam int AW      = $clog2(MAX_COLUMNS);
    localparam int IW      = ((AW > COL_W) ? AW : COL_W) + 1;
    localparam int COL_LIM = (MAX_COLUMNS < INDEX_SPAN) ? MAX_COLUMNS : INDEX_SPAN;

    logic signed [VALUE_W-1:0] vec_mem [MAX_COLUMNS];

    logic [CFG_W-1:0]          col_count_reg;
    logic [CFG_W-1:0]          row_count_reg;
    logic [CFG_W-1:0]          eff_cols;
    logic [CFG_W-1:0]          eff_rows;
    logic [COL_W-1:0]          last_col;

    logic [COL_W-1:0]          in_col;
    logic signed [VALUE_W-1:0] in_value;
    cmd_t                      in_cmd;
    logic [IW-1:0]             col_wide;
    logic [AW-1:0]             addr;
    logic                      in_mem;
    logic                      in_range;
    logic                      adv;
    logic                      accept;

    logic                      s1_valid_reg;
    logic                      s1_first_reg;
    logic                      s1_emit_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                      s2_valid_reg;
    logic                      s2_first_reg;
    logic                      s2_emit_reg;
    logic signed [ACC_W-1:0]   s2_prod_reg;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      s3_valid_reg;
    logic [ROW_W-1:0]          s3_row_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_inc;
    logic [ROW_W-1:0]          row_next;

    round_res_t                rnd;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_sum_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic                      out_sat_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= CFG_W'(512);
            row_count_reg <= CFG_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_COLUMNS: col_count_reg <= cfg_data;
                CFG_ROWS:    row_count_reg <= cfg_data;
                default:     col_count_reg <= col_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (col_count_reg == '0)
        begin
            eff_cols = CFG_W'(1);
        end
        else if (col_count_reg > CFG_W'(COL_LIM))
        begin
            eff_cols = CFG_W'(COL_LIM);
        end
        else
        begin
            eff_cols = col_count_reg;
        end

        if (row_count_reg == '0)
        begin
            eff_rows = CFG_W'(1);
        end
        else if (row_count_reg > CFG_W'(ROW_SPAN))
        begin
            eff_rows = CFG_W'(ROW_SPAN);
        end
        else
        begin
            eff_rows = row_count_reg;
        end
    end

    assign last_col = COL_W'(eff_cols - CFG_W'(1));

    // ---------------- input decode ----------------
    assign in_col   = s_tdata[COL_W-1:0];
    assign in_value = s_tdata[COL_W+VALUE_W-1:COL_W];
    assign in_cmd   = cmd_t'(s_tuser);
    assign col_wide = IW'(in_col);
    assign addr     = col_wide[AW-1:0];
    assign in_mem   = col_wide < IW'(MAX_COLUMNS);
    assign in_range = in_col <= last_col;

    // hold the whole pipe only when a row sum would overrun a waiting result
    assign adv      = !(s3_valid_reg && out_valid_reg && !m_tready);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // ---------------- vector store ----------------
    always_ff @(posedge clk)
    begin
        if (accept && in_cmd == CMD_LOAD && in_mem)
        begin
            vec_mem[addr] <= in_value;
        end
        if (accept && in_cmd == CMD_MATRIX)
        begin
            rd_data_reg <= vec_mem[addr];
        end
    end

    // ---------------- stage 1: read ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid && in_cmd == CMD_MATRIX && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= in_col == '0;
            s1_emit_reg  <= in_col == last_col;
            s1_value_reg <= in_value;
        end
    end

    // ---------------- stage 2: multiply ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            s2_first_reg <= s1_first_reg;
            s2_emit_reg  <= s1_emit_reg;
            s2_prod_reg  <= s1_value_reg * rd_data_reg;
        end
    end

    // ---------------- stage 3: accumulate ----------------
    assign acc_next = s2_first_reg ? s2_prod_reg : sat_add64(acc_reg, s2_prod_reg);
    assign row_inc  = row_reg + ROW_W'(1);
    assign row_next = ({1'b0, row_inc} >= eff_rows) ? '0 : row_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            row_reg      <= '0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg && s2_emit_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
                if (s2_emit_reg)
                begin
                    row_reg <= row_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && s2_emit_reg)
        begin
            s3_row_reg <= row_reg;
        end
    end

    // ---------------- stage 4: round into output register ----------------
    mvm_round u_round
    (
        .acc (acc_reg),
        .res (rnd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s3_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            out_sum_reg <= rnd.sum;
            out_sat_reg <= rnd.sat;
            out_row_reg <= s3_row_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_row_reg, out_sum_reg};
    assign m_tuser  = out_sat_reg;

endmodule

// ===== design/mvm_round.sv =====
// ----------------------------------------------------------------------------
// mvm_round
// Round a Q32.32 row sum to Q16.16 and clip it to 32 bits.
// ----------------------------------------------------------------------------
module mvm_round
    import mvm_pkg::*;
(
    input  logic signed [ACC_W-1:0] acc,
    output round_res_t              res
);

    localparam int Q_W = ACC_W - FRAC_W;

    logic signed [ACC_W-1:0] biased;
    logic signed [Q_W-1:0]   quot;
    logic                    fits;

    // round half up, then floor by an arithmetic shift
    assign biased = sat_add64(acc, ACC_W'(ROUND_HALF));
    assign quot   = biased[ACC_W-1:FRAC_W];
    assign fits   = (&quot[Q_W-1:VALUE_W-1]) || !(|quot[Q_W-1:VALUE_W-1]);

    always_comb
    begin
        if (fits)
        begin
            res.sum = quot[VALUE_W-1:0];
            res.sat = 1'b0;
        end
        else
        begin
            res.sum = quot[Q_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
            res.sat = 1'b1;
        end
    end

endmodule

// ===== design/mvm_checker.sv =====
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_defines.svh"

module mvm_checker
    import mvm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // row_sum, row_number, zero pad
    input logic                 m_tuser    // saturated
);

    localparam logic [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // hold the result until taken
    `MVM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `MVM_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // input backpressure only comes from a blocked output
    `MVM_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // a clipped sum sits at one of the limits
    `MVM_ASSERT_NOW(a_sat_limit, clk, rst_n, m_tvalid && m_tuser,
        m_tdata[VALUE_W-1:0] == SUM_MAX || m_tdata[VALUE_W-1:0] == SUM_MIN)

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply
// Self-checking bench for the matrix-vector multiply block. A row-sum tracker
// mirrors the vector store, the Q32.32 accumulator and the row counter. It
// predicts every rounded, clipped row sum from the words that the block
// accepts, and checks the words that leave the block in order. Directed rows
// cover clipping, rounding ties and a row count lowered under the current
// row. Random rows follow under several shapes and idle patterns, and the run
// ends with one full-width row.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply;
    import mvm_pkg::*;

    localparam int     CYCLE_LIMIT     = 400000;
    localparam int     LATENCY_PAUSE   = 8;
    localparam int     WORDS_PER_PHASE = 60;
    localparam longint ACC_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN         = -ACC_MAX - 1;
    localparam longint SUM_MAX         = 64'sd2147483647;
    localparam longint SUM_MIN         = -SUM_MAX - 1;

    typedef struct
    {
        logic signed [VALUE_W-1:0] sum;
        logic [ROW_W-1:0]          row;
        logic                      sat;
    } row_result_t;

    class row_sum_tracker;
        logic signed [VALUE_W-1:0] vector_entries [MAX_COLUMNS_DEF];
        longint                    acc;
        logic [ROW_W-1:0]          row_index;
        logic [CFG_W-1:0]          column_reg;
        logic [CFG_W-1:0]          row_reg;
        row_result_t               pending [$];
        int                        mismatches;

        function new();
            foreach (vector_entries[i])
                vector_entries[i] = '0;
            acc        = 0;
            row_index  = '0;
            column_reg = 10'd512;
            row_reg    = 10'd1;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
            if (idx == CFG_COLUMNS)
                column_reg = v;
            else
                row_reg = v;
        endfunction

        function int columns_in_use();
            int n;
            n = column_reg;
            if (n == 0)
                n = 1;
            if (n > MAX_COLUMNS_DEF)
                n = MAX_COLUMNS_DEF;
            return n;
        endfunction

        function int rows_in_use();
            int n;
            n = row_reg;
            if (n == 0)
                n = 1;
            if (n > ROW_SPAN)
                n = ROW_SPAN;
            return n;
        endfunction

        static function longint add_clipped(longint a, longint b);
            logic signed [ACC_W:0] wide;
            wide = a;
            wide = wide + b;
            if (wide > ACC_MAX)
                return ACC_MAX;
            if (wide < ACC_MIN)
                return ACC_MIN;
            return wide[ACC_W-1:0];
        endfunction

        function void take_word(cmd_t cmd, logic [COL_W-1:0] col,
                                logic signed [VALUE_W-1:0] value);
            longint      prod;
            longint      rounded;
            int          last_col;
            row_result_t res;
            if (cmd == CMD_LOAD)
            begin
                vector_entries[col] = value;
                return;
            end
            last_col = columns_in_use() - 1;
            if (col > last_col)
                return;
            prod = longint'(value) * longint'(vector_entries[col]);
            acc  = (col == 0) ? prod : add_clipped(acc, prod);
            if (col != last_col)
                return;
            // round half up from Q32.32 to Q16.16, then clip to 32 bits
            rounded = add_clipped(acc, ROUND_HALF) >>> FRAC_W;
            res.sat = 1'b0;
            if (rounded > SUM_MAX)
            begin
                rounded = SUM_MAX;
                res.sat = 1'b1;
            end
            else if (rounded < SUM_MIN)
            begin
                rounded = SUM_MIN;
                res.sat = 1'b1;
            end
            res.sum = rounded[VALUE_W-1:0];
            res.row = row_index;
            pending.push_back(res);
            row_index = row_index + 1'b1;
            if (row_index >= rows_in_use())
                row_index = '0;
        endfunction

        function void check_row(logic signed [VALUE_W-1:0] sum, logic [ROW_W-1:0] row,
                                logic sat);
            row_result_t want;
            if (pending.size() == 0)
            begin
                $error("row_sum: no row expected, actual %0d (row %0d)", sum, row);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (sum !== want.sum)
            begin
                $error("row_sum: expected %0d actual %0d", want.sum, sum);
                mismatches++;
            end
            if (row !== want.row)
            begin
                $error("row_number: expected %0d actual %0d", want.row, row);
                mismatches++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated: expected %0b actual %0b", want.sat, sat);
                mismatches++;
            end
        endfunction

        function int rows_waiting();
            return pending.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    cfg_index_t           cfg_index = CFG_COLUMNS;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    cmd_t                 s_tuser   = CMD_LOAD;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    row_sum_tracker tracker;
    logic           loaded [MAX_COLUMNS_DEF] = '{default: 1'b0};
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             words_sent    = 0;
    int             cycle_count   = 0;

    matrix_vector_multiply u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.take_word(s_tuser, s_tdata[COL_W-1:0], s_tdata[COL_W +: VALUE_W]);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_row(m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: ROW_W], m_tuser);
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(cmd_t cmd, logic [COL_W-1:0] col, logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - COL_W - VALUE_W){1'b0}}, value, col};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic load_entry(logic [COL_W-1:0] col, logic [VALUE_W-1:0] value);
        send_word(CMD_LOAD, col, value);
        loaded[col] = 1'b1;
    endtask

    // never let a live column read a store entry that was not written
    task automatic send_matrix(logic [COL_W-1:0] col, logic [VALUE_W-1:0] value);
        if (col < tracker.columns_in_use() && !loaded[col])
            load_entry(col, pick_value());
        send_word(CMD_MATRIX, col, value);
    endtask

    task automatic send_triplet(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                                logic [VALUE_W-1:0] c);
        send_matrix(9'd0, a);
        send_matrix(9'd1, b);
        send_matrix(9'd2, c);
    endtask

    task automatic send_noise(int cols);
        case ($urandom_range(0, 2))
            0: load_entry(COL_W'($urandom_range(0, MAX_COLUMNS_DEF - 1)), pick_value());
            1: send_matrix(COL_W'($urandom_range(0, MAX_COLUMNS_DEF - 1)), pick_value());
            default:
            begin
                if (cols < MAX_COLUMNS_DEF)
                    send_word(CMD_MATRIX,
                              COL_W'($urandom_range(cols, MAX_COLUMNS_DEF - 1)),
                              pick_value());
            end
        endcase
    endtask

    task automatic stream_row();
        int cols;
        cols = tracker.columns_in_use();
        for (int c = 0; c < cols; c++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_noise(cols);
            send_matrix(c[COL_W-1:0], pick_value());
        end
    endtask

    // hold the sender until every row sum is out and the pipeline is empty
    task automatic wait_rows_done();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.rows_waiting() != 0);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        tracker.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic program_shape(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        wait_rows_done();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        int               phase_start;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_shape(10'd3, 10'd5);
        load_entry(9'd0, 32'h8000_0000);
        load_entry(9'd1, 32'h8000_0000);
        load_entry(9'd2, 32'h0001_0000);
        // accumulator runs past both 64-bit limits
        send_triplet(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_triplet(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_triplet(32'h0000_0000, 32'h0000_0000, 32'h0001_8000);
        // a load between rows is used by the next row; exact half rounds up
        load_entry(9'd2, 32'h0000_8000);
        send_triplet(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        // drop the row count under the next row number
        wait_rows_done();
        write_reg(CFG_ROWS, 10'd2);
        cfg_wen <= 1'b0;
        // negative half rounds toward plus infinity
        send_triplet(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_MATRIX, 9'd511, 32'h1234_5678);
        send_triplet(32'h7FFF_FFFF, 32'h0000_0000, 32'h0002_0000);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0: cols = 10'd0;
                    1: cols = 10'd1;
                    2: cols = 10'd2;
                    default: cols = CFG_W'($urandom_range(3, 24));
                endcase
                case ($urandom_range(0, 9))
                    0: rows = 10'd0;
                    1: rows = 10'd1;
                    2: rows = 10'd512;
                    3: rows = 10'd1023;
                    default: rows = CFG_W'($urandom_range(2, 9));
                endcase
                program_shape(cols, rows);
                repeat ($urandom_range(1, 8)) stream_row();
            end
        end

        // one row across the whole store, column count above its size
        program_shape(10'd1023, 10'd1023);
        stream_row();
        wait_rows_done();

        if (tracker.mismatches == 0 && tracker.rows_waiting() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== matrix_vector_multiply.f =====
+incdir+design
design/mvm_pkg.sv
design/mvm_round.sv
design/matrix_vector_multiply.sv
design/mvm_checker.sv
bench/tb_matrix_vector_multiply.sv
